// File: rtl/skeleton_world_transform_chain_assert.svh
// ----------------------------------------------------------------------------
// skeleton world transform chain assertion macros
// concurrent assertion wrappers, clocked on clock, removable as a group
// ----------------------------------------------------------------------------
`ifndef SKELETON_WORLD_TRANSFORM_CHAIN_ASSERT_SVH
`define SKELETON_WORLD_TRANSFORM_CHAIN_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SWTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define SWTC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define SWTC_ASSERT(label, prop, msg)

`define SWTC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: rtl/swfk_pkg.sv
// ----------------------------------------------------------------------------
// swfk_pkg
// shared constants, types and saturation for the bone world transform chain
// ----------------------------------------------------------------------------
package swfk_pkg;

   localparam int MAX_BONES = 64;
   localparam int FRAC_BITS = 16;

   localparam int BONE_W = 6;
   localparam int COL_W  = 2;
   localparam int ELEM_W = 32;
   localparam int ROWS   = 4;
   localparam int IDX_W  = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

   localparam int PROD_W = 2 * ELEM_W;
   localparam int SH_W   = PROD_W - FRAC_BITS;
   localparam int PAIR_W = SH_W + 1;
   localparam int SUM_W  = SH_W + 2;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type [ROWS-1:0]       vec_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef sum_type [ROWS-1:0]        sum_vec_type;

   localparam elem_type FIX_ONE  = elem_type'(1 << FRAC_BITS);
   localparam elem_type FIX_ZERO = elem_type'(0);
   localparam elem_type ELEM_MAX = 32'sh7FFF_FFFF;
   localparam elem_type ELEM_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [BONE_W-1:0] bone;
      logic [COL_W-1:0]  column;
      logic              bad;
      logic              we;
      logic [IDX_W-1:0]  idx;
   } meta_type;

   typedef struct packed {
      logic ld2;
      logic ld3;
   } lane_ctl_type;

   function automatic elem_type sat_elem(input sum_type x);
      logic all_one;
      logic all_zero;
      all_one  = &x[SUM_W-1:ELEM_W-1];
      all_zero = ~(|x[SUM_W-1:ELEM_W-1]);
      if (all_one || all_zero) begin
         return elem_type'(x[ELEM_W-1:0]);
      end else if (x[SUM_W-1]) begin
         return ELEM_MIN;
      end else begin
         return ELEM_MAX;
      end
   endfunction

endpackage

// File: rtl/swfk_ram.sv
// ----------------------------------------------------------------------------
// swfk_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module swfk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/swfk_lane.sv
// ----------------------------------------------------------------------------
// swfk_lane
// one world row: four products, floor shift, pairwise sums, final sum
// ----------------------------------------------------------------------------
module swfk_lane (
   input  logic                   clock,
   input  swfk_pkg::lane_ctl_type ctl,
   input  swfk_pkg::vec_type      row,
   input  swfk_pkg::vec_type      e,
   output swfk_pkg::sum_type      sum
);

   logic signed [swfk_pkg::PROD_W-1:0] prod [swfk_pkg::ROWS];
   logic signed [swfk_pkg::SH_W-1:0]   p_in [swfk_pkg::ROWS];
   logic signed [swfk_pkg::SH_W-1:0]   p_ff [swfk_pkg::ROWS];
   logic signed [swfk_pkg::PAIR_W-1:0] q_in [2];
   logic signed [swfk_pkg::PAIR_W-1:0] q_ff [2];

   always_comb begin
      for (int k = 0; k < swfk_pkg::ROWS; k++) begin
         prod[k] = $signed(row[k]) * $signed(e[k]);
         p_in[k] = swfk_pkg::SH_W'(prod[k] >>> swfk_pkg::FRAC_BITS);
      end
   end

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         q_in[j] = swfk_pkg::PAIR_W'(p_ff[2*j]) + swfk_pkg::PAIR_W'(p_ff[2*j+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         for (int k = 0; k < swfk_pkg::ROWS; k++) begin
            p_ff[k] <= p_in[k];
         end
      end
      if (ctl.ld3) begin
         for (int j = 0; j < 2; j++) begin
            q_ff[j] <= q_in[j];
         end
      end
   end

   assign sum = swfk_pkg::SUM_W'(q_ff[0]) + swfk_pkg::SUM_W'(q_ff[1]);

endmodule

// File: rtl/swfk_merge.sv
// ----------------------------------------------------------------------------
// swfk_merge
// saturates the lane sums into one world column and holds the result register
// ----------------------------------------------------------------------------
module swfk_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  swfk_pkg::meta_type            meta,
   input  swfk_pkg::sum_vec_type         sums,
   output logic                          out_free,
   output swfk_pkg::vec_type             world,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swfk_pkg::BONE_W-1:0]   rsp_out_bone,
   output logic [swfk_pkg::COL_W-1:0]    rsp_out_column,
   output logic signed [swfk_pkg::ELEM_W-1:0] rsp_w0,
   output logic signed [swfk_pkg::ELEM_W-1:0] rsp_w1,
   output logic signed [swfk_pkg::ELEM_W-1:0] rsp_w2,
   output logic signed [swfk_pkg::ELEM_W-1:0] rsp_w3,
   output logic                          rsp_bad_parent
);

   logic                          out_v_ff;
   logic                          out_v_in;
   logic [swfk_pkg::BONE_W-1:0]   bone_ff;
   logic [swfk_pkg::COL_W-1:0]    column_ff;
   logic                          bad_ff;
   swfk_pkg::vec_type             w_ff;

   always_comb begin
      for (int r = 0; r < swfk_pkg::ROWS; r++) begin
         world[r] = swfk_pkg::sat_elem(sums[r]);
      end
   end

   assign out_free = !out_v_ff || rsp_ready;
   assign out_v_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         bone_ff   <= meta.bone;
         column_ff <= meta.column;
         bad_ff    <= meta.bad;
         w_ff      <= world;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_out_bone   = bone_ff;
   assign rsp_out_column = column_ff;
   assign rsp_w0         = w_ff[0];
   assign rsp_w1         = w_ff[1];
   assign rsp_w2         = w_ff[2];
   assign rsp_w3         = w_ff[3];
   assign rsp_bad_parent = bad_ff;

endmodule

// File: rtl/skeleton_world_transform_chain.sv
// ----------------------------------------------------------------------------
// skeleton_world_transform_chain
// pipeline: stages s1, s2 and s3, then the result register behind rsp_valid
// throughput: 1 transaction per cycle unless rsp_ready holds the result; a
//   transaction whose parent bone still has columns in the three compute
//   stages waits until they are written back to the world store
// reset: synchronous, clears pipeline valids; world store is not cleared
// ----------------------------------------------------------------------------
`include "skeleton_world_transform_chain_assert.svh"

module skeleton_world_transform_chain (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [swfk_pkg::BONE_W-1:0]          req_bone,
   input  logic                                 req_has_parent,
   input  logic [swfk_pkg::BONE_W-1:0]          req_parent,
   input  logic [swfk_pkg::COL_W-1:0]           req_column,
   input  logic signed [swfk_pkg::ELEM_W-1:0]   req_e0,
   input  logic signed [swfk_pkg::ELEM_W-1:0]   req_e1,
   input  logic signed [swfk_pkg::ELEM_W-1:0]   req_e2,
   input  logic signed [swfk_pkg::ELEM_W-1:0]   req_e3,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [swfk_pkg::BONE_W-1:0]          rsp_out_bone,
   output logic [swfk_pkg::COL_W-1:0]           rsp_out_column,
   output logic signed [swfk_pkg::ELEM_W-1:0]   rsp_w0,
   output logic signed [swfk_pkg::ELEM_W-1:0]   rsp_w1,
   output logic signed [swfk_pkg::ELEM_W-1:0]   rsp_w2,
   output logic signed [swfk_pkg::ELEM_W-1:0]   rsp_w3,
   output logic                                 rsp_bad_parent
);

   localparam int RAM_W = swfk_pkg::ROWS * swfk_pkg::ELEM_W;

   logic                          need;
   logic [swfk_pkg::IDX_W-1:0]    pidx;
   logic                          hazard;
   logic                          accept;
   logic                          en1;
   logic                          en2;
   logic                          en3;
   logic                          out_free;
   logic                          commit;
   swfk_pkg::lane_ctl_type        ctl;
   swfk_pkg::meta_type            req_meta;

   logic                          s1_v_ff, s1_v_in;
   logic                          s2_v_ff, s2_v_in;
   logic                          s3_v_ff, s3_v_in;
   swfk_pkg::meta_type            s1_meta_ff;
   swfk_pkg::meta_type            s2_meta_ff;
   swfk_pkg::meta_type            s3_meta_ff;
   logic                          s1_need_ff;
   logic [swfk_pkg::IDX_W-1:0]    s1_pidx_ff;
   swfk_pkg::vec_type             s1_e_ff;

   logic [RAM_W-1:0]              rd_data [swfk_pkg::ROWS];
   swfk_pkg::vec_type             rd_vec  [swfk_pkg::ROWS];
   logic [swfk_pkg::ROWS-1:0]     wr_en;
   swfk_pkg::vec_type             lane_row [swfk_pkg::ROWS];
   swfk_pkg::sum_vec_type         sums;
   swfk_pkg::vec_type             world;

   // parent used only when it precedes the bone and lies inside the store
   assign need = req_has_parent && (req_parent < req_bone)
                 && (32'(req_parent) < 32'(swfk_pkg::MAX_BONES));
   assign pidx = swfk_pkg::IDX_W'(req_parent);

   always_comb begin
      req_meta.bone   = req_bone;
      req_meta.column = req_column;
      req_meta.bad    = req_has_parent && !need;
      req_meta.we     = 32'(req_bone) < 32'(swfk_pkg::MAX_BONES);
      req_meta.idx    = swfk_pkg::IDX_W'(req_bone);
   end

   // parent columns still in flight have not reached the store
   assign hazard = need && (
         (s1_v_ff && s1_meta_ff.we && (s1_meta_ff.idx == pidx)) ||
         (s2_v_ff && s2_meta_ff.we && (s2_meta_ff.idx == pidx)) ||
         (s3_v_ff && s3_meta_ff.we && (s3_meta_ff.idx == pidx)));

   assign en3       = !s3_v_ff || out_free;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_ready = en1 && !hazard;
   assign accept    = req_valid && req_ready;
   assign ctl.ld2   = s1_v_ff && en2;
   assign ctl.ld3   = s2_v_ff && en3;
   assign commit    = s3_v_ff && out_free;

   assign s1_v_in = accept ? 1'b1 : (ctl.ld2 ? 1'b0 : s1_v_ff);
   assign s2_v_in = ctl.ld2 ? 1'b1 : (ctl.ld3 ? 1'b0 : s2_v_ff);
   assign s3_v_in = ctl.ld3 ? 1'b1 : (commit ? 1'b0 : s3_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= req_meta;
         s1_need_ff <= need;
         s1_pidx_ff <= pidx;
         s1_e_ff[0] <= req_e0;
         s1_e_ff[1] <= req_e1;
         s1_e_ff[2] <= req_e2;
         s1_e_ff[3] <= req_e3;
      end
      if (ctl.ld2) begin
         s2_meta_ff <= s1_meta_ff;
      end
      if (ctl.ld3) begin
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // world store: one ram per parent column, each word holds four rows
   for (genvar k = 0; k < swfk_pkg::ROWS; k++) begin : g_store
      assign wr_en[k] = commit && s3_meta_ff.we && (s3_meta_ff.column == swfk_pkg::COL_W'(k));
      assign rd_vec[k] = rd_data[k];

      swfk_ram #(
         .WIDTH (RAM_W),
         .DEPTH (swfk_pkg::MAX_BONES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[k]),
         .wr_addr (s3_meta_ff.idx),
         .wr_data (RAM_W'(world)),
         .rd_en   (accept),
         .rd_addr (pidx),
         .rd_data (rd_data[k])
      );
   end

   // lane r takes parent row r; identity row when no parent is used
   for (genvar r = 0; r < swfk_pkg::ROWS; r++) begin : g_lane
      always_comb begin
         for (int k = 0; k < swfk_pkg::ROWS; k++) begin
            if (s1_need_ff) begin
               lane_row[r][k] = rd_vec[k][r];
            end else if (k == r) begin
               lane_row[r][k] = swfk_pkg::FIX_ONE;
            end else begin
               lane_row[r][k] = swfk_pkg::FIX_ZERO;
            end
         end
      end

      swfk_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .row   (lane_row[r]),
         .e     (s1_e_ff),
         .sum   (sums[r])
      );
   end

   swfk_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .commit         (commit),
      .meta           (s3_meta_ff),
      .sums           (sums),
      .out_free       (out_free),
      .world          (world),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_bone   (rsp_out_bone),
      .rsp_out_column (rsp_out_column),
      .rsp_w0         (rsp_w0),
      .rsp_w1         (rsp_w1),
      .rsp_w2         (rsp_w2),
      .rsp_w3         (rsp_w3),
      .rsp_bad_parent (rsp_bad_parent)
   );

   `SWTC_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "result valid after reset")

   `SWTC_ASSERT(a_no_raw, s1_v_ff && s1_need_ff |-> !((s2_v_ff && s2_meta_ff.we && (s2_meta_ff.idx == s1_pidx_ff)) || (s3_v_ff && s3_meta_ff.we && (s3_meta_ff.idx == s1_pidx_ff))), "parent read overlaps pending write")

   `SWTC_ASSERT(a_s1_hold, s1_v_ff && !ctl.ld2 |=> s1_v_ff && $stable(s1_pidx_ff), "stalled stage lost its read")

endmodule
